// ----- src/lkl_pkg.sv -----
// Shared types, token codes and keyword tables for the logic keyword lexer.
package lkl_pkg;

   localparam int MAX_WORD_DEF   = 10;
   localparam int FIFO_DEPTH_DEF = 4;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 64;
   localparam int LINE_W         = 32;
   localparam int NUM_KW         = 7;
   localparam int KW_MAX_LEN     = 10;
   localparam int IDENT_BYTES    = 8;

   localparam logic [CSR_IDX_W-1:0]  CSR_IDENT_A       = 1'b0;
   localparam logic [CSR_IDX_W-1:0]  CSR_IDENT_B       = 1'b1;
   localparam logic [CSR_DATA_W-1:0] IDENT_A_RESET     = 64'd80;
   localparam logic [CSR_DATA_W-1:0] IDENT_B_RESET     = 64'd81;

   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;

   typedef enum logic [3:0] {
      TK_LPAREN  = 4'd0,
      TK_RPAREN  = 4'd1,
      TK_IDENT   = 4'd2,
      TK_AND     = 4'd3,
      TK_TRUE    = 4'd4,
      TK_FALSE   = 4'd5,
      TK_NOT     = 4'd6,
      TK_OR      = 4'd7,
      TK_IMPLIES = 4'd8,
      TK_EQUIV   = 4'd9,
      TK_END     = 4'd10,
      TK_UNKNOWN = 4'd11
   } token_kind_type;

   // Keyword text, first character in the lowest byte.
   localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [NUM_KW] = '{
      80'h444E41,
      80'h45555254,
      80'h45534C4146,
      80'h544F4E,
      80'h524F,
      80'h5345494C504D49,
      80'h544E454C415649555145
   };
   localparam logic [7:0] KW_LEN [NUM_KW] = '{8'd3, 8'd4, 8'd5, 8'd3, 8'd2, 8'd7, 8'd10};
   localparam token_kind_type KW_KIND [NUM_KW] = '{
      TK_AND, TK_TRUE, TK_FALSE, TK_NOT, TK_OR, TK_IMPLIES, TK_EQUIV
   };

   // Everything one input item yields, handed from the front to the back.
   typedef struct packed {
      logic               wrd_en;
      token_kind_type     wrd_kind;
      logic [7:0]         wrd_len;
      logic [7:0]         wrd_first;
      logic               chr_en;
      token_kind_type     chr_kind;
      logic [7:0]         chr_code;
      logic               end_en;
      logic [LINE_W-1:0]  line_pre;
      logic [LINE_W-1:0]  line_post;
   } lkl_entry_type;

   typedef struct packed {
      token_kind_type     kind;
      logic [7:0]         len;
      logic [7:0]         first;
      logic [LINE_W-1:0]  line;
      logic               last;
   } lkl_token_type;

endpackage

// ----- src/lkl_ifs.sv -----
// Handshake channel interfaces for source characters and tokens.
interface lkl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       char_valid;
   logic       end_of_source;

   modport source (output valid, char_code, char_valid, end_of_source, input ready);
   modport sink (input valid, char_code, char_valid, end_of_source, output ready);
endinterface

interface lkl_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [7:0]  lexeme_length;
   logic [7:0]  first_char;
   logic [31:0] line_number;
   logic        last_of_run;

   modport source (output valid, token_kind, lexeme_length, first_char, line_number,
                   last_of_run, input ready);
   modport sink (input valid, token_kind, lexeme_length, first_char, line_number,
                 last_of_run, output ready);
endinterface

// ----- src/lkl_front.sv -----
// Front end: accepts characters, collects words, classifies and queues token records.
module lkl_front #(
   parameter int MAX_WORD = lkl_pkg::MAX_WORD_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   lkl_req_if.sink                       req_ch,
   input  logic                          csr_write_en,
   input  logic [lkl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lkl_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                          q_full,
   output logic                          q_push,
   output lkl_pkg::lkl_entry_type        q_data
);
   import lkl_pkg::*;

   localparam int IDX_W = $clog2(MAX_WORD);

   logic [7:0]            word_buf_ff [MAX_WORD];
   logic [7:0]            word_buf_in [MAX_WORD];
   logic [7:0]            word_len_ff, word_len_in, len_mid;
   logic                  word_pend_ff, word_pend_in, pend_mid;
   logic [LINE_W-1:0]     line_ff, line_in, line_post;
   logic [CSR_DATA_W-1:0] ident_a_ff, ident_b_ff;

   logic                  accept, is_letter, is_space, flush;
   logic [7:0]            c;
   logic [8*IDENT_BYTES-1:0] packed_word;
   logic                  kw_hit;
   token_kind_type        kw_kind, word_kind;
   lkl_entry_type         ent;

   assign req_ch.ready = !q_full;
   assign accept = req_ch.valid && !q_full;
   assign c = req_ch.char_code;

   always_comb begin
      is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
      is_space  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);

      // Word state after the character, before any flush.
      word_buf_in = word_buf_ff;
      len_mid     = word_len_ff;
      pend_mid    = word_pend_ff;
      if (req_ch.char_valid && is_letter) begin
         for (int i = 0; i < MAX_WORD; i++) begin
            if (word_len_ff < 8'(MAX_WORD) && word_len_ff[IDX_W-1:0] == IDX_W'(i)) begin
               word_buf_in[i] = c;
            end
         end
         if (word_len_ff != 8'hFF) begin
            len_mid = word_len_ff + 8'd1;
         end
         pend_mid = 1'b1;
      end

      kw_hit  = 1'b0;
      kw_kind = TK_UNKNOWN;
      for (int k = NUM_KW - 1; k >= 0; k--) begin
         logic eq;
         eq = (len_mid == KW_LEN[k]);
         for (int i = 0; i < KW_MAX_LEN; i++) begin
            if (8'(i) < KW_LEN[k] && word_buf_in[i] != KW_TEXT[k][8*i +: 8]) begin
               eq = 1'b0;
            end
         end
         if (eq) begin
            kw_hit  = 1'b1;
            kw_kind = KW_KIND[k];
         end
      end

      for (int i = 0; i < IDENT_BYTES; i++) begin
         packed_word[8*i +: 8] = (8'(i) < len_mid) ? word_buf_in[i] : 8'h00;
      end

      if (len_mid > 8'(MAX_WORD)) begin
         word_kind = TK_UNKNOWN;
      end else if (kw_hit) begin
         word_kind = kw_kind;
      end else if (len_mid <= 8'(IDENT_BYTES)
                   && (packed_word == ident_a_ff || packed_word == ident_b_ff)) begin
         word_kind = TK_IDENT;
      end else begin
         word_kind = TK_UNKNOWN;
      end

      flush = (req_ch.char_valid && !is_letter) || req_ch.end_of_source;

      line_post = line_ff;
      if (req_ch.char_valid && c == CH_NEWLINE && line_ff != '1) begin
         line_post = line_ff + LINE_W'(1);
      end

      ent.wrd_en    = pend_mid && flush;
      ent.wrd_kind  = word_kind;
      ent.wrd_len   = len_mid;
      ent.wrd_first = word_buf_in[0];
      ent.chr_en    = req_ch.char_valid && !is_letter && !is_space;
      if (c == CH_LPAREN) begin
         ent.chr_kind = TK_LPAREN;
      end else if (c == CH_RPAREN) begin
         ent.chr_kind = TK_RPAREN;
      end else begin
         ent.chr_kind = TK_UNKNOWN;
      end
      ent.chr_code  = c;
      ent.end_en    = req_ch.end_of_source;
      ent.line_pre  = line_ff;
      ent.line_post = line_post;

      word_len_in  = flush ? 8'd0 : len_mid;
      word_pend_in = flush ? 1'b0 : pend_mid;
      line_in      = req_ch.end_of_source ? LINE_W'(1) : line_post;
   end

   assign q_data = ent;
   assign q_push = accept && (ent.wrd_en || ent.chr_en || ent.end_en);

   always_ff @(posedge clock) begin
      if (accept) begin
         word_buf_ff <= word_buf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_len_ff  <= 8'd0;
         word_pend_ff <= 1'b0;
         line_ff      <= LINE_W'(1);
      end else if (accept) begin
         word_len_ff  <= word_len_in;
         word_pend_ff <= word_pend_in;
         line_ff      <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ident_a_ff <= IDENT_A_RESET;
         ident_b_ff <= IDENT_B_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_IDENT_A: ident_a_ff <= csr_wdata;
            CSR_IDENT_B: ident_b_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

// ----- src/lkl_fifo.sv -----
// Short queue of token records between the front end and the back end.
module lkl_fifo #(
   parameter int DEPTH = lkl_pkg::FIFO_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lkl_pkg::lkl_entry_type push_data,
   input  logic                   pop,
   output lkl_pkg::lkl_entry_type head,
   output logic                   empty,
   output logic                   full
);
   import lkl_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lkl_entry_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/lkl_back.sv -----
// Back end: expands each token record into up to three tokens on the output register.
module lkl_back (
   input  logic                   clock,
   input  logic                   reset,
   input  lkl_pkg::lkl_entry_type head,
   input  logic                   q_empty,
   output logic                   q_pop,
   lkl_rsp_if.source              rsp_ch
);
   import lkl_pkg::*;

   logic          out_valid_ff, out_valid_in;
   lkl_token_type out_ff, out_in;
   logic          done_wrd_ff, done_wrd_in, done_chr_ff, done_chr_in;
   logic          advance, pend_wrd, pend_chr;

   assign advance  = !out_valid_ff || rsp_ch.ready;
   assign pend_wrd = head.wrd_en && !done_wrd_ff;
   assign pend_chr = head.chr_en && !done_chr_ff;

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      done_wrd_in  = done_wrd_ff;
      done_chr_in  = done_chr_ff;
      q_pop        = 1'b0;
      if (advance) begin
         out_valid_in = !q_empty;
         if (!q_empty) begin
            // The word goes first, then the character's token, then the end token.
            if (pend_wrd) begin
               out_in.kind  = head.wrd_kind;
               out_in.len   = head.wrd_len;
               out_in.first = head.wrd_first;
               out_in.line  = head.line_pre;
               out_in.last  = !pend_chr && !head.end_en;
               done_wrd_in  = 1'b1;
            end else if (pend_chr) begin
               out_in.kind  = head.chr_kind;
               out_in.len   = 8'd1;
               out_in.first = head.chr_code;
               out_in.line  = head.line_pre;
               out_in.last  = !head.end_en;
               done_chr_in  = 1'b1;
            end else begin
               out_in.kind  = TK_END;
               out_in.len   = 8'd0;
               out_in.first = 8'd0;
               out_in.line  = head.line_post;
               out_in.last  = 1'b1;
            end
            if (out_in.last) begin
               q_pop       = 1'b1;
               done_wrd_in = 1'b0;
               done_chr_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         done_wrd_ff  <= 1'b0;
         done_chr_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         done_wrd_ff  <= done_wrd_in;
         done_chr_ff  <= done_chr_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.token_kind    = out_ff.kind;
   assign rsp_ch.lexeme_length = out_ff.len;
   assign rsp_ch.first_char    = out_ff.first;
   assign rsp_ch.line_number   = out_ff.line;
   assign rsp_ch.last_of_run   = out_ff.last;

endmodule

// ----- src/logic_keyword_lexer.sv -----
// Top level of the logic keyword lexer: front end, record queue and back end.
// A token is registered in the record queue and then in the output register on its
// way from an accepted input item to rsp_ch.
// Throughput: one character per cycle while the queue is not full; tokens leave
// at one per cycle while rsp_ch is ready, an item's tokens before the next item's.
// Reset (synchronous, active high) empties the queue and output register, clears the
// pending word, sets the line count to one and the identifier names to P and Q.
module logic_keyword_lexer #(
   parameter int MAX_WORD   = lkl_pkg::MAX_WORD_DEF,
   parameter int FIFO_DEPTH = lkl_pkg::FIFO_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   lkl_req_if.sink                        req_ch,
   lkl_rsp_if.source                      rsp_ch,
   input  logic                           csr_write_en,
   input  logic [lkl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lkl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lkl_pkg::*;

   lkl_entry_type q_in, q_head;
   logic          q_push, q_pop, q_empty, q_full;

   lkl_front #(.MAX_WORD(MAX_WORD)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_in)
   );

   lkl_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   lkl_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (q_head),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule
